[hw/rtl/box_difference_edge_filter_defines.svh]
// Assertion macros shared by the box difference edge filter checkers.
// Sampled on clk; the checker must see clk and arst_n by those names.
`ifndef BOX_DIFFERENCE_EDGE_FILTER_DEFINES_SVH
`define BOX_DIFFERENCE_EDGE_FILTER_DEFINES_SVH

// Checked outside reset only
`define BDEF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define BDEF_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/bdef_pkg.sv]
// Shared constants and types for the box difference edge filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdef_pkg;

	localparam int unsigned MAX_WINDOW = 31;
	localparam int unsigned COUNT_BITS = 24;
	localparam int unsigned WIN_W      = 5;
	localparam int unsigned SUM_W      = 29;
	localparam int unsigned BINS_W     = 6;
	localparam int unsigned HIST_AW    = 6;
	localparam int unsigned HIST_DEPTH = 2 ** HIST_AW;
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 32;
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [WIN_W-1:0] win_t;

	// Prefix sums taken at the current bin: P[k], P[k-W], P[k-2W]
	typedef struct packed {
		sum_t pk;
		sum_t pa;
		sum_t pb;
	} taps_t;

endpackage

`default_nettype wire

[hw/rtl/bdef_prefix.sv]
// Running prefix sum of bin counts with a ring of past prefix values.
// Gives the three prefix taps that bound both summing windows. Uses bdef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdef_prefix (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [bdef_pkg::COUNT_BITS-1:0] bin,
	input  bdef_pkg::win_t                 win,
	output bdef_pkg::taps_t                taps
);
	import bdef_pkg::*;

	logic [HIST_AW-1:0] wr_ptr_q;
	sum_t               acc_q;
	sum_t               hist [HIST_DEPTH];
	logic [HIST_AW-1:0] rd_a;
	logic [HIST_AW-1:0] rd_b;
	sum_t               pk_s1;
	sum_t               pa_s1;
	sum_t               pb_s1;
	sum_t               acc_s1;
	logic               byp_s1;

	// Slot of bin j holds the prefix before bin j, so sums are differences
	// of slots; wraparound mod 2^SUM_W is harmless since a window fits.
	assign rd_a = wr_ptr_q - HIST_AW'(win) + HIST_AW'(1);
	assign rd_b = wr_ptr_q - HIST_AW'({win, 1'b0}) + HIST_AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			acc_q    <= '0;
		end else if (push) begin
			wr_ptr_q <= wr_ptr_q + HIST_AW'(1);
			acc_q    <= acc_q + SUM_W'(bin);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hist[wr_ptr_q] <= acc_q;
			pa_s1          <= hist[rd_a];
			pb_s1          <= hist[rd_b];
			pk_s1          <= acc_q + SUM_W'(bin);
			acc_s1         <= acc_q;
			byp_s1         <= (win == WIN_W'(1));
		end
	end

	// With a one-bin window the newer tap is the slot being written now
	assign taps.pk = pk_s1;
	assign taps.pa = byp_s1 ? acc_s1 : pa_s1;
	assign taps.pb = pb_s1;

endmodule

`default_nettype wire

[hw/rtl/box_difference_edge_filter.sv]
// Box difference edge filter: max(0, older window sum - newer window sum).
// Throughput: one bin per cycle while the output is not stalled; the final bin stays
// in the input stage until its results (W, or the unanswered bins of a short spectrum)
// have all moved out, and the next bin is taken in the cycle its last result moves out.
// Reset: arst_n clears control, the running prefix sum and counts; window_length is 8.
// Uses bdef_pkg and bdef_prefix.
`timescale 1ns / 1ps
`default_nettype none

module box_difference_edge_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bdef_pkg::WIN_W-1:0]      cfg_wdata,   // window_length
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bdef_pkg::IN_DATA_W-1:0]  s_tdata,     // [23:0] bin_count
	input  logic                           s_tlast,     // final_bin
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bdef_pkg::OUT_DATA_W-1:0] m_tdata,     // [28:0] edge_value, zero above
	output logic                           m_tlast,     // run_end
	output logic                           m_tuser      // too_short
);
	import bdef_pkg::*;

	typedef enum logic [1:0] {
		KIND_PAD,
		KIND_DIFF,
		KIND_LAST_FULL,
		KIND_LAST_SHORT
	} kind_t;

	win_t              win_cfg_q;
	win_t              win_eff;
	logic [BINS_W-1:0] two_w;
	logic [BINS_W-1:0] win6;
	logic [BINS_W-1:0] bins_q;
	logic [BINS_W-1:0] prior;
	logic [BINS_W-1:0] k;
	logic [BINS_W-1:0] bins_d;
	kind_t             kind_d;
	win_t              reps_d;
	logic              has_result;
	logic              accept;

	logic              s1_valid_q;
	kind_t             kind_s1;
	win_t              reps_s1;
	win_t              cnt_q;
	logic              emit;
	logic              s1_done;
	taps_t             taps;
	sum_t              newer;
	sum_t              older;
	sum_t              diff;
	sum_t              value;
	sum_t              prev_q;

	logic              out_valid_q;
	sum_t              edge_q;
	logic              last_q;
	logic              short_q;

	assign win_eff = (win_cfg_q == '0) ? WIN_W'(1) : win_cfg_q;
	assign two_w   = {win_eff, 1'b0};
	assign win6    = BINS_W'(win_eff);
	assign prior   = (bins_q > two_w) ? two_w : bins_q;
	assign k       = prior + BINS_W'(1);
	assign accept  = s_tvalid && s_tready;

	always_comb begin
		kind_d     = KIND_PAD;
		reps_d     = WIN_W'(1);
		has_result = 1'b1;
		bins_d     = (k > two_w) ? two_w : k;
		if (s_tlast) begin
			bins_d = '0;
			if (k >= two_w) begin
				kind_d = KIND_LAST_FULL;
				reps_d = win_eff;
			end else begin
				kind_d = KIND_LAST_SHORT;
				reps_d = (k <= win6) ? WIN_W'(1) : WIN_W'(k - win6);
			end
		end else if (k <= win6) begin
			kind_d = KIND_PAD;
		end else if (k >= two_w) begin
			kind_d = KIND_DIFF;
		end else begin
			// bin is only stored
			has_result = 1'b0;
		end
	end

	bdef_prefix u_prefix (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.bin    (COUNT_BITS'(s_tdata)),
		.win    (win_eff),
		.taps   (taps)
	);

	assign newer = taps.pk - taps.pa;
	assign older = taps.pa - taps.pb;
	assign diff  = (older > newer) ? (older - newer) : '0;

	always_comb begin
		case (kind_s1)
			KIND_DIFF:      value = diff;
			KIND_LAST_FULL: value = prev_q;
			default:        value = '0;
		endcase
	end

	assign emit     = s1_valid_q && (!out_valid_q || m_tready);
	assign s1_done  = ((cnt_q + WIN_W'(1)) == reps_s1);
	assign s_tready = !s1_valid_q || (emit && s1_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg_q   <= WIN_RESET;
			bins_q      <= '0;
			s1_valid_q  <= 1'b0;
			kind_s1     <= KIND_PAD;
			reps_s1     <= WIN_W'(1);
			cnt_q       <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_cfg_q <= cfg_wdata;
			end
			if (accept) begin
				bins_q     <= bins_d;
				s1_valid_q <= has_result;
				kind_s1    <= kind_d;
				reps_s1    <= reps_d;
			end else if (emit && s1_done) begin
				s1_valid_q <= 1'b0;
			end
			if (emit) begin
				cnt_q       <= s1_done ? '0 : cnt_q + WIN_W'(1);
				out_valid_q <= 1'b1;
				case (kind_s1)
					KIND_PAD:  prev_q <= '0;
					KIND_DIFF: prev_q <= diff;
					default: begin
						// end of spectrum: start the next one from zero
						if (s1_done) begin
							prev_q <= '0;
						end
					end
				endcase
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			edge_q  <= value;
			last_q  <= s1_done && (kind_s1 == KIND_LAST_FULL || kind_s1 == KIND_LAST_SHORT);
			short_q <= (kind_s1 == KIND_LAST_SHORT);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(edge_q);
	assign m_tlast  = last_q;
	assign m_tuser  = short_q;

endmodule

`default_nettype wire

[hw/rtl/bdef_checker.sv]
// Port-level checks for the box difference edge filter, bound to the top.
// Uses bdef_pkg and box_difference_edge_filter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "box_difference_edge_filter_defines.svh"

module bdef_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bdef_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast,
	input logic                           m_tuser
);

	`BDEF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "stalled result request dropped")
	`BDEF_ASSERT(a_short_zero, m_tvalid && m_tuser |-> m_tdata == '0, "short spectrum result not zero")
	`BDEF_ASSERT(a_short_burst, m_tvalid && m_tready && m_tuser && !m_tlast |=> m_tvalid && m_tuser, "short spectrum results broken up")
	`BDEF_ASSERT_NR(a_reset_idle, !arst_n |=> !m_tvalid && s_tready, "block not idle in reset")

endmodule

bind box_difference_edge_filter bdef_checker u_bdef_checker (.*);

`default_nettype wire
